// ===== rtl/ipv6ew_pkg.sv =====
// ipv6ew_pkg: shared types, constants and helpers for the ipv6 extension header walker
// no dependencies; used by the parser core, the top level and the bench

package ipv6ew_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_EXT_NH  = 3'd1,
    PH_EXT_LEN = 3'd2,
    PH_DONE    = 3'd3,
    PH_DROP    = 3'd4
  } parse_phase_e;

  // verdict codes
  typedef enum logic [3:0] {
    V_ACCEPT    = 4'd0,
    V_IGNORED   = 4'd1,
    V_TRUNCATED = 4'd2,
    V_FRAGMENT  = 4'd3,
    V_EXT_LONG  = 4'd4,
    V_BEYOND    = 4'd5,
    V_EMPTY     = 4'd6,
    V_OVER_SNAP = 4'd7,
    V_NOT_UDP   = 4'd8
  } verdict_e;

  // next-header protocol numbers
  localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
  localparam logic [7:0] NH_UDP        = 8'd17;
  localparam logic [7:0] NH_ROUTING    = 8'd43;
  localparam logic [7:0] NH_FRAGMENT   = 8'd44;
  localparam logic [7:0] NH_ESP        = 8'd50;
  localparam logic [7:0] NH_AH         = 8'd51;
  localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

  // fixed header layout
  localparam logic [15:0] IDX_PLEN_HI   = 16'd4;
  localparam logic [15:0] IDX_PLEN_LO   = 16'd5;
  localparam logic [15:0] IDX_NEXT_HDR  = 16'd6;
  localparam logic [15:0] IDX_FIXED_END = 16'd39;
  localparam logic [15:0] FIXED_HDR_LEN = 16'd40;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  localparam logic [15:0] SNAP_RESET = 16'd1460;

  // one verdict with its fields
  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [7:0]  final_next_header;
  } result_t;

  // true for the extension headers that the walker recognises; a fragment header ends the walk with a drop
  function automatic logic is_ext(input logic [7:0] nh);
    return (nh == NH_HOP_BY_HOP) || (nh == NH_ROUTING) || (nh == NH_FRAGMENT) ||
           (nh == NH_ESP) || (nh == NH_AH) || (nh == NH_DEST_OPTS);
  endfunction

endpackage

// ===== rtl/ipv6ew_byte_if.sv =====
// ipv6ew_byte_if: valid/ready channel carrying packet bytes into the walker
// no dependencies

interface ipv6ew_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       source_ignored;

  modport source (output valid, output data_byte, output last_byte, output source_ignored,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input source_ignored,
                output ready);
endinterface

// ===== rtl/ipv6ew_verdict_if.sv =====
// ipv6ew_verdict_if: valid/ready channel carrying one verdict per packet
// no dependencies

interface ipv6ew_verdict_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [15:0] payload_offset;
  logic [15:0] payload_length;
  logic [7:0]  final_next_header;

  modport source (output valid, output verdict, output payload_offset,
                  output payload_length, output final_next_header, input ready);
  modport sink (input valid, input verdict, input payload_offset,
                input payload_length, input final_next_header, output ready);
endinterface

// ===== rtl/ipv6ew_core.sv =====
// ipv6ew_core: per-packet parse state, one byte step and the verdict of the last byte
// depends on ipv6ew_pkg

module ipv6ew_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic                source_ignored_i,
  input  logic [15:0]         snap_limit_i,
  output ipv6ew_pkg::result_t result_o
);

  logic [15:0]              pos_q, pos_d;
  logic [7:0]               cur_nh_q, cur_nh_d;
  logic [15:0]              remain_q, remain_d;
  logic [15:0]              hdr_start_q, hdr_start_d;
  logic [7:0]               pending_q, pending_d;
  ipv6ew_pkg::parse_phase_e phase_q, phase_d;
  ipv6ew_pkg::verdict_e     drop_q, drop_d;

  logic [11:0] hdr_len;
  logic [16:0] next_start;
  logic        take;
  ipv6ew_pkg::verdict_e verdict;

  // extension header size 8*(len+1) and where the following header starts
  assign hdr_len    = {1'b0, data_byte_i, 3'b000} + 12'd8;
  assign next_start = {1'b0, hdr_start_q} + {5'b0, hdr_len};
  assign take       = (pos_q != ipv6ew_pkg::POS_MAX);

  // next state for one byte
  always_comb begin
    pos_d       = pos_q;
    cur_nh_d    = cur_nh_q;
    remain_d    = remain_q;
    hdr_start_d = hdr_start_q;
    pending_d   = pending_q;
    phase_d     = phase_q;
    drop_d      = drop_q;
    if (take) begin
      pos_d = pos_q + 16'd1;
      case (phase_q)
        ipv6ew_pkg::PH_FIXED: begin
          if (pos_q == ipv6ew_pkg::IDX_PLEN_HI) begin
            remain_d = {data_byte_i, remain_q[7:0]};
          end else if (pos_q == ipv6ew_pkg::IDX_PLEN_LO) begin
            remain_d = {remain_q[15:8], data_byte_i};
          end else if (pos_q == ipv6ew_pkg::IDX_NEXT_HDR) begin
            cur_nh_d = data_byte_i;
          end else if (pos_q == ipv6ew_pkg::IDX_FIXED_END) begin
            phase_d = ipv6ew_pkg::is_ext(cur_nh_q) ? ipv6ew_pkg::PH_EXT_NH
                                                   : ipv6ew_pkg::PH_DONE;
          end
        end
        ipv6ew_pkg::PH_EXT_NH: begin
          if (pos_q == hdr_start_q) begin
            pending_d = data_byte_i;
            phase_d   = ipv6ew_pkg::PH_EXT_LEN;
          end
        end
        ipv6ew_pkg::PH_EXT_LEN: begin
          if (cur_nh_q == ipv6ew_pkg::NH_FRAGMENT) begin
            drop_d  = ipv6ew_pkg::V_FRAGMENT;
            phase_d = ipv6ew_pkg::PH_DROP;
          end else if ({4'b0, hdr_len} > remain_q) begin
            drop_d  = ipv6ew_pkg::V_EXT_LONG;
            phase_d = ipv6ew_pkg::PH_DROP;
          end else begin
            remain_d = remain_q - {4'b0, hdr_len};
            cur_nh_d = pending_q;
            if (next_start[16]) begin
              // header runs past the last representable offset
              drop_d  = ipv6ew_pkg::is_ext(pending_q) ? ipv6ew_pkg::V_TRUNCATED
                                                      : ipv6ew_pkg::V_BEYOND;
              phase_d = ipv6ew_pkg::PH_DROP;
            end else begin
              hdr_start_d = next_start[15:0];
              phase_d     = ipv6ew_pkg::is_ext(pending_q) ? ipv6ew_pkg::PH_EXT_NH
                                                          : ipv6ew_pkg::PH_DONE;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // verdict on the state after this byte
  always_comb begin
    if (pos_d < ipv6ew_pkg::FIXED_HDR_LEN) begin
      verdict = ipv6ew_pkg::V_TRUNCATED;
    end else if (source_ignored_i) begin
      verdict = ipv6ew_pkg::V_IGNORED;
    end else if (phase_d == ipv6ew_pkg::PH_DROP) begin
      verdict = drop_d;
    end else if (phase_d != ipv6ew_pkg::PH_DONE) begin
      verdict = ipv6ew_pkg::V_TRUNCATED;
    end else if (({1'b0, hdr_start_d} + {1'b0, remain_d}) > {1'b0, pos_d}) begin
      verdict = ipv6ew_pkg::V_BEYOND;
    end else if (remain_d == 16'd0) begin
      verdict = ipv6ew_pkg::V_EMPTY;
    end else if (remain_d > snap_limit_i) begin
      verdict = ipv6ew_pkg::V_OVER_SNAP;
    end else if (cur_nh_d != ipv6ew_pkg::NH_UDP) begin
      verdict = ipv6ew_pkg::V_NOT_UDP;
    end else begin
      verdict = ipv6ew_pkg::V_ACCEPT;
    end
  end

  // result fields, cleared for the early drop reasons
  always_comb begin
    result_o.verdict = verdict;
    if (verdict == ipv6ew_pkg::V_IGNORED || verdict == ipv6ew_pkg::V_TRUNCATED ||
        verdict == ipv6ew_pkg::V_FRAGMENT || verdict == ipv6ew_pkg::V_EXT_LONG) begin
      result_o.payload_offset    = 16'd0;
      result_o.payload_length    = 16'd0;
      result_o.final_next_header = 8'd0;
    end else begin
      result_o.payload_offset    = hdr_start_d;
      result_o.payload_length    = remain_d;
      result_o.final_next_header = cur_nh_d;
    end
  end

  // state registers, back to the packet start after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 16'd0;
      cur_nh_q    <= 8'd0;
      remain_q    <= 16'd0;
      hdr_start_q <= ipv6ew_pkg::FIXED_HDR_LEN;
      pending_q   <= 8'd0;
      phase_q     <= ipv6ew_pkg::PH_FIXED;
      drop_q      <= ipv6ew_pkg::V_ACCEPT;
    end else if (step_i) begin
      if (last_byte_i) begin
        pos_q       <= 16'd0;
        cur_nh_q    <= 8'd0;
        remain_q    <= 16'd0;
        hdr_start_q <= ipv6ew_pkg::FIXED_HDR_LEN;
        pending_q   <= 8'd0;
        phase_q     <= ipv6ew_pkg::PH_FIXED;
        drop_q      <= ipv6ew_pkg::V_ACCEPT;
      end else begin
        pos_q       <= pos_d;
        cur_nh_q    <= cur_nh_d;
        remain_q    <= remain_d;
        hdr_start_q <= hdr_start_d;
        pending_q   <= pending_d;
        phase_q     <= phase_d;
        drop_q      <= drop_d;
      end
    end
  end

endmodule

// ===== rtl/ipv6_extension_header_walker_unit.sv =====
// ipv6_extension_header_walker_unit: top level of the ipv6 extension header walker
// depends on ipv6ew_pkg, ipv6ew_byte_if, ipv6ew_verdict_if and ipv6ew_core
//
// usage:
//   byte_in carries a captured ipv6 packet one byte per request, in order,
//   last_byte set on its final byte; source_ignored is sampled with that byte.
//   verdict_out carries one request per packet: the verdict code, the payload
//   offset and length after the extension chain and the final next header.
//   cfg_we_i / cfg_wdata_i write the snap limit; write it only while idle.
// pipeline and throughput:
//   a byte is taken into an input register and parsed from there; the
//   verdict of a last byte is then loaded into the output register. one
//   byte per cycle is sustained while no last byte waits on a stalled verdict;
//   a single parse step lies between the input and output registers.
// reset:
//   clears both pipeline registers and the parse state; snap limit is 1460.
// stall:
//   while a verdict waits in the output register, plain bytes keep flowing;
//   only the next last byte holds in the input register until it is taken.

module ipv6_extension_header_walker_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  ipv6ew_byte_if.sink             byte_in,
  ipv6ew_verdict_if.source        verdict_out,
  input  logic                    cfg_we_i,
  input  logic [15:0]             cfg_wdata_i
);

  logic [15:0]         snap_q;
  logic                s1_valid_q;
  logic [7:0]          s1_byte_q;
  logic                s1_last_q;
  logic                s1_ign_q;
  logic                advance;
  logic                out_valid_q;
  ipv6ew_pkg::result_t out_q;
  ipv6ew_pkg::result_t core_res;

  // snap limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q <= ipv6ew_pkg::SNAP_RESET;
    end else if (cfg_we_i) begin
      snap_q <= cfg_wdata_i;
    end
  end

  // input stage moves on unless a verdict would overrun a stalled output
  assign advance      = s1_valid_q && (!s1_last_q || !out_valid_q || verdict_out.ready);
  assign byte_in.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid_q <= byte_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_byte_q <= byte_in.data_byte;
      s1_last_q <= byte_in.last_byte;
      s1_ign_q  <= byte_in.source_ignored;
    end
  end

  // parse step
  ipv6ew_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .data_byte_i      (s1_byte_q),
    .last_byte_i      (s1_last_q),
    .source_ignored_i (s1_ign_q),
    .snap_limit_i     (snap_q),
    .result_o         (core_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (verdict_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      out_q <= core_res;
    end
  end

  assign verdict_out.valid             = out_valid_q;
  assign verdict_out.verdict           = out_q.verdict;
  assign verdict_out.payload_offset    = out_q.payload_offset;
  assign verdict_out.payload_length    = out_q.payload_length;
  assign verdict_out.final_next_header = out_q.final_next_header;

`ifndef SYNTHESIS
  // a last byte facing a stalled verdict is kept, not lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && out_valid_q && !verdict_out.ready |=>
      s1_valid_q && s1_last_q && out_valid_q)
    else $error("last byte lost under output stall");

  // verdict codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.verdict <= ipv6ew_pkg::V_NOT_UDP)
    else $error("undefined verdict code");

  // early drop reasons carry cleared fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.verdict == ipv6ew_pkg::V_IGNORED ||
                    out_q.verdict == ipv6ew_pkg::V_TRUNCATED ||
                    out_q.verdict == ipv6ew_pkg::V_FRAGMENT ||
                    out_q.verdict == ipv6ew_pkg::V_EXT_LONG) |->
      out_q.payload_offset == 16'd0 && out_q.payload_length == 16'd0 &&
      out_q.final_next_header == 8'd0)
    else $error("drop verdict with nonzero fields");

  // a new verdict is loaded only when the previous one has left or leaves now
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_last_q |-> !out_valid_q || verdict_out.ready)
    else $error("verdict overwritten");
`endif

endmodule

// ===== tb/tb_ipv6_extension_header_walker_unit.sv =====
// tb_ipv6_extension_header_walker_unit: self-checking bench for the ipv6 extension header walker
// depends on ipv6ew_pkg, ipv6ew_byte_if, ipv6ew_verdict_if and ipv6_extension_header_walker_unit
// drives packets byte by byte, predicts each verdict and checks it field by field
`timescale 1ns / 1ps

module tb_ipv6_extension_header_walker_unit;
  import ipv6ew_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int SEGMENTS = 6;
  localparam int SEGMENT_BYTES = 100;
  localparam int SEGMENT_FRAMES = 2;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
    logic       ignored;
  } pkt_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  ipv6ew_byte_if    byte_in ();
  ipv6ew_verdict_if verdict_out ();

  ipv6_extension_header_walker_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_in     (byte_in),
    .verdict_out (verdict_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // stimulus and scoreboard storage
  pkt_byte_t   byte_backlog[$];
  result_t     pending_verdicts[$];
  logic [7:0]  frame_q[$];
  pkt_byte_t   cur_req;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatch_count = 0;

  // shadow of the walker state
  logic [15:0]  snap_q;
  logic [15:0]  pos_q;
  logic [15:0]  rem_q;
  logic [15:0]  hstart_q;
  logic [15:0]  hlen_q;
  logic [7:0]   nh_q;
  logic [7:0]   pend_nh_q;
  parse_phase_e phase_q;
  verdict_e     drop_q;

  function automatic logic walks_over(input logic [7:0] nh);
    return nh == NH_HOP_BY_HOP || nh == NH_ROUTING || nh == NH_FRAGMENT ||
           nh == NH_ESP || nh == NH_AH || nh == NH_DEST_OPTS;
  endfunction

  function automatic void clear_walk();
    pos_q     = '0;
    rem_q     = '0;
    hstart_q  = FIXED_HDR_LEN;
    hlen_q    = '0;
    nh_q      = '0;
    pend_nh_q = '0;
    phase_q   = PH_FIXED;
    drop_q    = V_ACCEPT;
  endfunction

  function automatic void latch_drop(input verdict_e why);
    drop_q  = why;
    phase_q = PH_DROP;
  endfunction

  // one byte through the header state machine
  function automatic void parse_byte(input logic [15:0] idx, input logic [7:0] b);
    logic [16:0] next_start;
    case (phase_q)
      PH_FIXED: begin
        if (idx == IDX_PLEN_HI) rem_q[15:8] = b;
        else if (idx == IDX_PLEN_LO) rem_q[7:0] = b;
        else if (idx == IDX_NEXT_HDR) nh_q = b;
        else if (idx == IDX_FIXED_END) phase_q = walks_over(nh_q) ? PH_EXT_NH : PH_DONE;
      end
      PH_EXT_NH: begin
        if (idx == hstart_q) begin
          pend_nh_q = b;
          phase_q   = PH_EXT_LEN;
        end
      end
      PH_EXT_LEN: begin
        if (nh_q == NH_FRAGMENT) begin
          latch_drop(V_FRAGMENT);
        end else begin
          hlen_q = {5'd0, b, 3'd0} + 16'd8;
          if (hlen_q > rem_q) begin
            latch_drop(V_EXT_LONG);
          end else begin
            next_start = {1'b0, hstart_q} + {1'b0, hlen_q};
            rem_q      = rem_q - hlen_q;
            nh_q       = pend_nh_q;
            if (next_start[16]) begin
              latch_drop(walks_over(nh_q) ? V_TRUNCATED : V_BEYOND);
            end else begin
              hstart_q = next_start[15:0];
              phase_q  = walks_over(nh_q) ? PH_EXT_NH : PH_DONE;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // verdict for the packet that just ended
  function automatic verdict_e judge_packet(input logic ignored);
    if (pos_q < FIXED_HDR_LEN) return V_TRUNCATED;
    if (ignored) return V_IGNORED;
    if (phase_q == PH_DROP) return drop_q;
    if (phase_q != PH_DONE) return V_TRUNCATED;
    if ({1'b0, hstart_q} + {1'b0, rem_q} > {1'b0, pos_q}) return V_BEYOND;
    if (rem_q == 16'd0) return V_EMPTY;
    if (rem_q > snap_q) return V_OVER_SNAP;
    if (nh_q != NH_UDP) return V_NOT_UDP;
    return V_ACCEPT;
  endfunction

  function automatic void walk_byte(input pkt_byte_t req, output bit has_verdict,
                                    output result_t res);
    verdict_e v;
    has_verdict = 1'b0;
    res = '0;
    if (pos_q != POS_MAX) begin
      parse_byte(pos_q, req.value);
      pos_q = pos_q + 16'd1;
    end
    if (req.is_last) begin
      v = judge_packet(req.ignored);
      has_verdict = 1'b1;
      res.verdict = v;
      if (v == V_ACCEPT || v >= V_BEYOND) begin
        res.payload_offset    = hstart_q;
        res.payload_length    = rem_q;
        res.final_next_header = nh_q;
      end
      clear_walk();
    end
  endfunction

  // packet construction
  function automatic void start_frame(input logic [15:0] plen, input logic [7:0] nh);
    frame_q.delete();
    repeat (40) frame_q.push_back(8'($urandom));
    frame_q[IDX_PLEN_HI] = plen[15:8];
    frame_q[IDX_PLEN_LO] = plen[7:0];
    frame_q[IDX_NEXT_HDR] = nh;
  endfunction

  function automatic void add_fill(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void add_ext(input logic [7:0] next_nh, input logic [7:0] len_byte);
    frame_q.push_back(next_nh);
    frame_q.push_back(len_byte);
    add_fill(8 * (int'(len_byte) + 1) - 2);
  endfunction

  function automatic int queue_frame(input bit ignored);
    pkt_byte_t req;
    for (int i = 0; i < frame_q.size(); i++) begin
      req.value   = frame_q[i];
      req.is_last = (i == frame_q.size() - 1);
      req.ignored = req.is_last ? ignored : 1'($urandom);
      byte_backlog.push_back(req);
    end
    return frame_q.size();
  endfunction

  function automatic logic [7:0] pick_ext();
    case ($urandom_range(10))
      0, 1:    return NH_HOP_BY_HOP;
      2, 3:    return NH_ROUTING;
      4:       return NH_FRAGMENT;
      5, 6:    return NH_ESP;
      7, 8:    return NH_AH;
      default: return NH_DEST_OPTS;
    endcase
  endfunction

  // mostly well-formed chains with random content, some noise and cut packets
  function automatic int random_frame();
    logic [7:0]  chain_nh[5];
    logic [7:0]  len_byte[4];
    logic [15:0] plen;
    int n_ext, fill, sum, pick;
    bit ignored;
    ignored = ($urandom_range(9) == 0);
    if ($urandom_range(99) < 15) begin
      frame_q.delete();
      add_fill($urandom_range(1, 90));
      return queue_frame(ignored);
    end
    n_ext = $urandom_range(0, 3);
    sum = 0;
    for (int i = 0; i < n_ext; i++) begin
      chain_nh[i] = pick_ext();
      pick = $urandom_range(99);
      if (pick < 85) len_byte[i] = 8'($urandom_range(0, 3));
      else len_byte[i] = 8'($urandom_range(4, 15));
      sum += 8 * (int'(len_byte[i]) + 1);
    end
    chain_nh[n_ext] = ($urandom_range(99) < 80) ? NH_UDP : 8'($urandom);
    fill = $urandom_range(0, 40);
    pick = $urandom_range(99);
    if (pick < 75) plen = 16'(sum + fill);
    else if (pick < 85) plen = 16'($urandom);
    else plen = 16'(sum + fill + $urandom_range(0, 16) - 8);
    start_frame(plen, chain_nh[0]);
    for (int i = 0; i < n_ext; i++) add_ext(chain_nh[i + 1], len_byte[i]);
    add_fill(fill);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
    end
    return queue_frame(ignored);
  endfunction

  // byte driver: presents backlog entries, predicts each accepted request
  always @(posedge clk_i) begin : drive_bytes
    bit got;
    result_t res;
    if (!rst_ni) begin
      byte_in.valid <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        walk_byte(cur_req, got, res);
        if (got) pending_verdicts.push_back(res);
      end
      if (!byte_in.valid || byte_in.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = byte_backlog.pop_front();
          byte_in.valid          <= 1'b1;
          byte_in.data_byte      <= cur_req.value;
          byte_in.last_byte      <= cur_req.is_last;
          byte_in.source_ignored <= cur_req.ignored;
        end else begin
          byte_in.valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor: compares each accepted verdict with the oldest prediction
  always @(posedge clk_i) begin : check_verdicts
    result_t want;
    if (!rst_ni) begin
      verdict_out.ready <= 1'b0;
    end else begin
      if (verdict_out.valid && verdict_out.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("verdict request %0d with no packet pending", verdict_out.verdict);
          mismatch_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict_out.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, verdict_out.verdict);
            mismatch_count++;
          end
          if (verdict_out.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %0d, got %0d", want.payload_offset,
                   verdict_out.payload_offset);
            mismatch_count++;
          end
          if (verdict_out.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d", want.payload_length,
                   verdict_out.payload_length);
            mismatch_count++;
          end
          if (verdict_out.final_next_header !== want.final_next_header) begin
            $error("final_next_header: expected %0d, got %0d", want.final_next_header,
                   verdict_out.final_next_header);
            mismatch_count++;
          end
        end
      end
      verdict_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (byte_backlog.size() != 0 || byte_in.valid || pending_verdicts.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_snap(input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    snap_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // main sequence
  initial begin : run_packets
    logic [7:0] plain_ext[5];
    logic [15:0] snap_val;
    int seg_bytes, seg_frames, waited;
    plain_ext = '{NH_HOP_BY_HOP, NH_ROUTING, NH_ESP, NH_AH, NH_DEST_OPTS};
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    byte_in.valid          = 1'b0;
    byte_in.data_byte      = '0;
    byte_in.last_byte      = 1'b0;
    byte_in.source_ignored = 1'b0;
    verdict_out.ready      = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 68;
    snap_q = SNAP_RESET;
    clear_walk();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed packets at the reset snap limit
    start_frame(16'd8, NH_UDP); add_fill(8); void'(queue_frame(1'b0));
    start_frame(16'd8, NH_UDP); add_fill(8); void'(queue_frame(1'b1));
    // short packet wins over the ignore flag
    start_frame(16'd8, NH_UDP); void'(frame_q.pop_back()); void'(queue_frame(1'b1));
    frame_q.delete(); frame_q.push_back(8'hFF); void'(queue_frame(1'b0));
    start_frame(16'd0, NH_UDP); void'(queue_frame(1'b0));
    start_frame(16'd16, 8'd6); add_fill(16); void'(queue_frame(1'b0));
    start_frame(16'hFFFF, NH_UDP); add_fill(10); void'(queue_frame(1'b0));
    foreach (plain_ext[i]) begin
      start_frame(16'd16, plain_ext[i]); add_ext(NH_UDP, 8'd0); add_fill(8);
      void'(queue_frame(1'b0));
    end
    start_frame(16'd16, NH_FRAGMENT); add_ext(NH_UDP, 8'd0); add_fill(8);
    void'(queue_frame(1'b0));
    // fragment header cut after its next-header byte
    start_frame(16'd16, NH_FRAGMENT); frame_q.push_back(NH_UDP); void'(queue_frame(1'b0));
    // extension announced but packet ends with the fixed header
    start_frame(16'd16, NH_ROUTING); void'(queue_frame(1'b0));
    start_frame(16'd16, NH_HOP_BY_HOP); add_ext(NH_UDP, 8'd10); add_fill(4);
    void'(queue_frame(1'b0));
    start_frame(16'd32, NH_HOP_BY_HOP); add_ext(NH_ROUTING, 8'd0);
    add_ext(NH_DEST_OPTS, 8'd0); add_ext(NH_UDP, 8'd0); add_fill(8);
    void'(queue_frame(1'b0));
    // largest header size against a small payload, packet ends after the length byte
    start_frame(16'd16, NH_DEST_OPTS); frame_q.push_back(NH_UDP);
    frame_q.push_back(8'd255); void'(queue_frame(1'b0));

    // random segments, each under its own snap limit; the idle pattern changes every two segments
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_for_drain();
      if (seg < 2) begin
        send_idle_pct = 25;
        recv_idle_pct = 68;
      end else if (seg < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0:       snap_val = 16'hFFFF;
        1:       snap_val = 16'd1;
        2:       snap_val = SNAP_RESET;
        3:       snap_val = 16'($urandom_range(1, 120));
        4:       snap_val = 16'd64;
        default: snap_val = 16'($urandom_range(1, 65535));
      endcase
      write_snap(snap_val);
      @(negedge clk_i);
      seg_bytes = 0;
      seg_frames = 0;
      while (seg_bytes < SEGMENT_BYTES || seg_frames < SEGMENT_FRAMES) begin
        seg_bytes += random_frame();
        seg_frames++;
      end
    end

    // all requests out, then a bounded wait for the last verdicts
    do @(negedge clk_i);
    while (byte_backlog.size() != 0 || byte_in.valid);
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < 500) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d predicted verdicts never arrived", pending_verdicts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
